>>> rtl/serial_line_relay_command_assert.svh
// ----------------------------------------------------------------------------
// Serial line relay command assertion macros
// Shared property forms for the checker of the relay command receiver.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_RELAY_COMMAND_ASSERT_SVH
`define SERIAL_LINE_RELAY_COMMAND_ASSERT_SVH

// same-cycle implication
`define SLRC_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLRC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/slrc_pkg.sv
// ----------------------------------------------------------------------------
// slrc_pkg
// Types and constants shared by the relay command receiver modules.
// ----------------------------------------------------------------------------
package slrc_pkg;

	localparam int CHANNELS = 6;

	localparam logic [7:0] CHAR_CR   = 8'h0d;
	localparam logic [7:0] CHAR_LF   = 8'h0a;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_MIN = 8'(CHAR_ZERO + 1);
	localparam logic [7:0] DIGIT_MAX = 8'(CHAR_ZERO + CHANNELS);

	localparam logic [1:0] ST_OPENED   = 2'd0;
	localparam logic [1:0] ST_CLOSED   = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ECHO   = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEND,
		S_LOAD
	} state_t;

	typedef struct packed {
		logic take;
		logic issue_rd;
		logic load_echo;
	} cmd_t;

	typedef struct packed {
		logic line_done;
		logic last;
	} sts_t;

endpackage

>>> rtl/serial_line_relay_command.sv
// ----------------------------------------------------------------------------
// serial_line_relay_command
// Line receiver for CR LF terminated relay commands with line echo.
// ----------------------------------------------------------------------------
// Bytes enter on the rx channel (rx_valid, rx_ready, rx_byte) and are kept in
// a line buffer of BUFFER_DEPTH entries. A CR followed by LF completes the
// line; a CR followed by any other byte drops the line.
// Ordinary bytes and dropped lines are taken back to back while idle.
// A completed line gives one status result, then one echo result per stored
// byte, on the res channel (res_valid, res_ready and the result fields), with
// last marking the final result. The status result is registered at the LF
// transfer and appears in the next cycle; each echo byte passes through the
// registered read of the line buffer, then the result register. No byte is
// taken while a line is being sent. A stalled receiver holds the result
// register and the sequence unchanged. Reset clears the line count, the CR
// flag and all relay levels; the buffer contents stay undefined. Writing
// cfg_wdata under cfg_we sets every relay level and the indicator to it.
// ----------------------------------------------------------------------------
module serial_line_relay_command #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          kind,
	output logic [1:0]                    cmd_status,
	output logic [2:0]                    channel_number,
	output logic [slrc_pkg::CHANNELS-1:0] left_relays,
	output logic [slrc_pkg::CHANNELS-1:0] right_relays,
	output logic                          indicator,
	output logic [7:0]                    echo_byte,
	output logic                          last
);
	import slrc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	slrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slrc_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.cmd_status     (cmd_status),
		.channel_number (channel_number),
		.left_relays    (left_relays),
		.right_relays   (right_relays),
		.indicator      (indicator),
		.echo_byte      (echo_byte),
		.last           (last)
	);

endmodule

>>> rtl/slrc_ctrl.sv
// ----------------------------------------------------------------------------
// slrc_ctrl
// Sequencer for byte intake, status delivery and line echo.
// ----------------------------------------------------------------------------
module slrc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rx_valid,
	output logic          rx_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  slrc_pkg::sts_t sts,
	output slrc_pkg::cmd_t cmd
);
	import slrc_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		rx_ready      = 1'b0;
		res_valid     = 1'b0;
		cmd           = '0;
		case (state_q)
			S_IDLE: begin
				rx_ready = 1'b1;
				cmd.take = rx_valid;
				if (rx_valid && sts.line_done) begin
					state_nx = S_SEND;
				end
			end
			S_SEND: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (sts.last) begin
						state_nx = S_IDLE;
					end else begin
						cmd.issue_rd = 1'b1;
						state_nx     = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				cmd.load_echo = 1'b1;
				state_nx      = S_SEND;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/slrc_dp.sv
// ----------------------------------------------------------------------------
// slrc_dp
// Line buffer, relay levels and result register of the command receiver.
// ----------------------------------------------------------------------------
module slrc_dp #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [7:0]                    rx_byte,
	input  slrc_pkg::cmd_t                cmd,
	output slrc_pkg::sts_t                sts,
	output logic                          kind,
	output logic [1:0]                    cmd_status,
	output logic [2:0]                    channel_number,
	output logic [slrc_pkg::CHANNELS-1:0] left_relays,
	output logic [slrc_pkg::CHANNELS-1:0] right_relays,
	output logic                          indicator,
	output logic [7:0]                    echo_byte,
	output logic                          last
);
	import slrc_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0]          mem [BUFFER_DEPTH];
	logic [AW-1:0]       count_q;
	logic                got_cr_q;
	logic [7:0]          first_q;
	logic [CHANNELS-1:0] left_q;
	logic [CHANNELS-1:0] right_q;
	logic                ind_q;
	logic [AW-1:0]       len_q;
	logic [AW-1:0]       idx_q;
	logic [7:0]          rd_q;

	logic                kind_q;
	logic [1:0]          status_q;
	logic [2:0]          chan_q;
	logic [CHANNELS-1:0] left_out_q;
	logic [CHANNELS-1:0] right_out_q;
	logic                ind_out_q;
	logic [7:0]          echo_q;
	logic                last_q;

	logic [AW:0]         cnt_inc;
	logic [AW-1:0]       cnt_nx;
	logic                store;
	logic                complete;
	logic                cmd_ok;
	logic [7:0]          ch_raw;
	logic [2:0]          ch;
	logic [CHANNELS-1:0] bit_vec;
	logic [CHANNELS-1:0] left_nx;
	logic [CHANNELS-1:0] right_nx;
	logic                lv;
	logic                rv;
	logic [1:0]          st_nx;
	logic                ind_nx;
	logic [AW:0]         idx_inc;

	assign sts.line_done = got_cr_q && (rx_byte == CHAR_LF);
	assign sts.last      = last_q;

	assign complete = cmd.take && sts.line_done;
	assign store    = cmd.take && !got_cr_q && (rx_byte != CHAR_CR);

	assign cnt_inc = {1'b0, count_q} + 1'b1;
	assign cnt_nx  = (cnt_inc == (AW+1)'(BUFFER_DEPTH)) ? '0 : cnt_inc[AW-1:0];
	assign idx_inc = {1'b0, idx_q} + 1'b1;

	always_comb begin
		cmd_ok  = (first_q >= DIGIT_MIN) && (first_q <= DIGIT_MAX);
		ch_raw  = first_q - CHAR_ZERO;
		ch      = cmd_ok ? ch_raw[2:0] : 3'd0;
		bit_vec = cmd_ok ? (CHANNELS'(1) << (ch - 3'd1)) : '0;
		left_nx  = left_q ^ bit_vec;
		right_nx = right_q ^ bit_vec;
		lv = |(left_nx & bit_vec);
		rv = |(right_nx & bit_vec);
		ind_nx = ind_q;
		if (!cmd_ok) begin
			st_nx = ST_INVALID;
		end else if (lv != rv) begin
			st_nx = ST_MISMATCH;
		end else if (rv) begin
			st_nx  = ST_OPENED;
			ind_nx = 1'b1;
		end else begin
			st_nx  = ST_CLOSED;
			ind_nx = 1'b0;
		end
	end

	// line buffer
	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q] <= rx_byte;
		end
		if (cmd.issue_rd) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (store && (count_q == '0)) begin
			first_q <= rx_byte;
		end
	end

	// line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			got_cr_q <= 1'b0;
		end else if (cmd.take) begin
			if (got_cr_q) begin
				count_q  <= '0;
				got_cr_q <= 1'b0;
			end else if (rx_byte == CHAR_CR) begin
				got_cr_q <= 1'b1;
			end else begin
				count_q <= cnt_nx;
			end
		end
	end

	// relay levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			ind_q   <= 1'b0;
		end else if (cfg_we) begin
			left_q  <= {CHANNELS{cfg_wdata}};
			right_q <= {CHANNELS{cfg_wdata}};
			ind_q   <= cfg_wdata;
		end else if (complete) begin
			left_q  <= left_nx;
			right_q <= right_nx;
			ind_q   <= ind_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (complete) begin
			kind_q      <= KIND_STATUS;
			status_q    <= st_nx;
			chan_q      <= ch;
			left_out_q  <= left_nx;
			right_out_q <= right_nx;
			ind_out_q   <= ind_nx;
			echo_q      <= '0;
			last_q      <= (count_q == '0);
			len_q       <= count_q;
			idx_q       <= '0;
		end else if (cmd.load_echo) begin
			kind_q      <= KIND_ECHO;
			status_q    <= ST_OPENED;
			chan_q      <= '0;
			left_out_q  <= '0;
			right_out_q <= '0;
			ind_out_q   <= 1'b0;
			echo_q      <= rd_q;
			last_q      <= (idx_inc == {1'b0, len_q});
			idx_q       <= idx_inc[AW-1:0];
		end
	end

	assign kind           = kind_q;
	assign cmd_status     = status_q;
	assign channel_number = chan_q;
	assign left_relays    = left_out_q;
	assign right_relays   = right_out_q;
	assign indicator      = ind_out_q;
	assign echo_byte      = echo_q;
	assign last           = last_q;

endmodule

>>> rtl/slrc_chk.sv
// ----------------------------------------------------------------------------
// slrc_chk
// Port-level checker for the relay command receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_line_relay_command_assert.svh"

module slrc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rx_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          kind,
	input logic [1:0]                    cmd_status,
	input logic [2:0]                    channel_number,
	input logic [slrc_pkg::CHANNELS-1:0] left_relays,
	input logic [slrc_pkg::CHANNELS-1:0] right_relays,
	input logic                          indicator,
	input logic [7:0]                    echo_byte,
	input logic                          last
);
	import slrc_pkg::*;

	`SLRC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(kind) && $stable(echo_byte) && $stable(last),
		"result changed while stalled")

	`SLRC_ASSERT_NOW(a_no_intake, clk, arst_n, res_valid, !rx_ready,
		"byte taken while a result is pending")

	`SLRC_ASSERT_NOW(a_echo_clean, clk, arst_n, res_valid && (kind == KIND_ECHO),
		(cmd_status == ST_OPENED) && (channel_number == 3'd0) && (left_relays == '0)
		&& (right_relays == '0) && !indicator, "echo transfer carries status fields")

	`SLRC_ASSERT_NOW(a_status_clean, clk, arst_n, res_valid && (kind == KIND_STATUS),
		(echo_byte == 8'd0) && ((cmd_status == ST_INVALID) == (channel_number == 3'd0)),
		"status transfer inconsistent")

endmodule

bind serial_line_relay_command slrc_chk u_slrc_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_ready       (rx_ready),
	.res_valid      (res_valid),
	.res_ready      (res_ready),
	.kind           (kind),
	.cmd_status     (cmd_status),
	.channel_number (channel_number),
	.left_relays    (left_relays),
	.right_relays   (right_relays),
	.indicator      (indicator),
	.echo_byte      (echo_byte),
	.last           (last)
);
